### src/dtq_pkg.sv
// Shared types and codes for the deadline timer queue.
package dtq_pkg;

    localparam logic [2:0] KIND_COMPARE = 3'd0;
    localparam logic [2:0] KIND_SCHEDULE = 3'd1;
    localparam logic [2:0] KIND_CANCEL = 3'd2;
    localparam logic [2:0] KIND_QUERY = 3'd3;
    localparam logic [2:0] KIND_READ_TIME = 3'd4;

    localparam logic [1:0] RES_FIRED = 2'd0;
    localparam logic [1:0] RES_COMPARE = 2'd1;
    localparam logic [1:0] RES_STATUS = 2'd2;
    localparam logic [1:0] RES_TIME = 2'd3;

    localparam logic CFG_MIN_INTERVAL = 1'b0;
    localparam logic CFG_MAX_INTERVAL = 1'b1;

    localparam logic [15:0] MIN_INTERVAL_RESET = 16'd50;
    localparam logic [15:0] MAX_INTERVAL_RESET = 16'd50000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRE,
        S_INSERT,
        S_SCHED,
        S_CANCEL,
        S_QUERY,
        S_TIME,
        S_CMP
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_FIRE,
        OP_SCHED,
        OP_CANCEL,
        OP_INS_STEP,
        OP_EMIT_CMP,
        OP_EMIT_QUERY,
        OP_EMIT_TIME
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic entry_ok;
        logic fire_due;
        logic fire_periodic;
        logic ins_done;
        logic ins_head;
    } dp_status_t;

endpackage

### src/dtq_ctrl.sv
// Sequencing state machine of the deadline timer queue.
module dtq_ctrl
    import dtq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] kind,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    ctrl_state_t state_reg, state_next;
    logic        fire_ctx_reg, fire_ctx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fire_ctx_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fire_ctx_reg <= fire_ctx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fire_ctx_next = fire_ctx_reg;
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_ACCEPT;
                    case (kind)
                        KIND_COMPARE: state_next = S_FIRE;
                        KIND_SCHEDULE: state_next = status.entry_ok ? S_SCHED : S_IDLE;
                        KIND_CANCEL: state_next = status.entry_ok ? S_CANCEL : S_IDLE;
                        KIND_QUERY: state_next = S_QUERY;
                        KIND_READ_TIME: state_next = S_TIME;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_FIRE:
            begin
                if (status.fire_due)
                begin
                    cmd.op = OP_FIRE;
                    if (status.fire_periodic)
                    begin
                        fire_ctx_next = 1'b1;
                        state_next = S_INSERT;
                    end
                end
                else
                begin
                    cmd.op = OP_EMIT_CMP;
                    state_next = S_IDLE;
                end
            end
            S_SCHED:
            begin
                cmd.op = OP_SCHED;
                fire_ctx_next = 1'b0;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.op = OP_INS_STEP;
                if (status.ins_done)
                begin
                    if (fire_ctx_reg)
                        state_next = S_FIRE;
                    else if (status.ins_head)
                        state_next = S_CMP;
                    else
                        state_next = S_IDLE;
                end
            end
            S_CANCEL:
            begin
                cmd.op = OP_CANCEL;
                state_next = S_IDLE;
            end
            S_QUERY:
            begin
                cmd.op = OP_EMIT_QUERY;
                state_next = S_IDLE;
            end
            S_TIME:
            begin
                cmd.op = OP_EMIT_TIME;
                state_next = S_IDLE;
            end
            S_CMP:
            begin
                cmd.op = OP_EMIT_CMP;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### src/dtq_datapath.sv
// Time extension, entry tables, sorted queue and result registers.
module dtq_datapath
    import dtq_pkg::*;
#(
    parameter int NUM_ENTRIES = 16,
    parameter int MAX_FIRES = 32,
    parameter int COUNTER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [15:0] counter_sample,
    input  logic [3:0]  entry_index,
    input  logic        absolute_start,
    input  logic [63:0] start_time,
    input  logic [31:0] repeat_period,
    output logic        result_valid,
    output logic [1:0]  result_kind,
    output logic [3:0]  fired_entry,
    output logic [15:0] compare_value,
    output logic        has_fired,
    output logic [63:0] time_now,
    output logic        last_of_run
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int LEN_W = $clog2(NUM_ENTRIES + 1);
    localparam int FIRE_W = $clog2(MAX_FIRES + 1);
    localparam logic [63:0] CNT_MASK = (64'd1 << COUNTER_WIDTH) - 64'd1;
    localparam logic [63:0] CNT_PERIOD = 64'd1 << COUNTER_WIDTH;

    logic [15:0]              min_reg, max_reg;
    logic [63:0]              time_base_reg;
    logic [COUNTER_WIDTH-1:0] prev_reg;
    logic [63:0]              now_reg;
    logic [63:0]              deadline_reg [NUM_ENTRIES];
    logic [31:0]              period_reg [NUM_ENTRIES];
    logic [IDX_W-1:0]         order_reg [NUM_ENTRIES];
    logic [LEN_W-1:0]         len_reg;
    logic [FIRE_W-1:0]        fires_reg;
    logic [LEN_W-1:0]         pos_reg;
    logic [IDX_W-1:0]         ins_reg;
    logic [IDX_W-1:0]         ent_reg;
    logic                     ent_ok_reg;
    logic                     abs_reg;
    logic [63:0]              start_reg;
    logic [31:0]              rper_reg;

    logic                     valid_reg;
    logic [1:0]               rkind_reg;
    logic [3:0]               fired_reg;
    logic [15:0]              cmp_reg;
    logic                     has_reg;
    logic                     last_reg;

    logic [COUNTER_WIDTH-1:0] sample;
    logic [63:0]              tb_next;
    logic [IDX_W-1:0]         head;
    logic [63:0]              head_dl;
    logic [IDX_W-1:0]         pos_idx;
    logic [63:0]              pos_dl;
    logic                     found;
    logic [IDX_W-1:0]         found_pos;
    logic [63:0]              now_min, now_max, next_dl;

    assign sample = COUNTER_WIDTH'(counter_sample);
    assign tb_next = (sample < prev_reg) ? time_base_reg + CNT_PERIOD : time_base_reg;
    assign head = order_reg[0];
    assign head_dl = deadline_reg[head];
    assign pos_idx = pos_reg[IDX_W-1:0];
    assign pos_dl = deadline_reg[order_reg[pos_idx]];

    // Slot of the latched entry within the live part of the queue.
    always_comb
    begin
        found = 1'b0;
        found_pos = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if ((LEN_W'(i) < len_reg) && (order_reg[i] == ent_reg))
            begin
                found = 1'b1;
                found_pos = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        now_min = now_reg + 64'(min_reg);
        now_max = now_reg + 64'(max_reg);
        next_dl = now_max;
        if (len_reg != '0)
        begin
            if (head_dl <= now_min)
                next_dl = now_min;
            else if (head_dl < now_max)
                next_dl = head_dl;
        end
    end

    assign status.entry_ok = ({3'b000, entry_index} < 7'(NUM_ENTRIES));
    assign status.fire_due = (fires_reg < FIRE_W'(MAX_FIRES)) && (len_reg != '0)
                             && (head_dl <= now_reg);
    assign status.fire_periodic = (period_reg[head] != 32'd0);
    assign status.ins_done = (pos_reg >= len_reg)
                             || (deadline_reg[ins_reg] < pos_dl);
    assign status.ins_head = (pos_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_INTERVAL_RESET;
            max_reg <= MAX_INTERVAL_RESET;
            time_base_reg <= '0;
            prev_reg <= '0;
            len_reg <= '0;
            valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                deadline_reg[i] <= '0;
                period_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_write)
            begin
                if (cfg_index == CFG_MIN_INTERVAL)
                    min_reg <= cfg_data;
                else
                    max_reg <= cfg_data;
            end
            case (cmd.op)
                OP_ACCEPT:
                begin
                    time_base_reg <= tb_next;
                    prev_reg <= sample;
                end
                OP_FIRE:
                begin
                    for (int i = 0; i < NUM_ENTRIES - 1; i++)
                        order_reg[i] <= order_reg[i + 1];
                    len_reg <= len_reg - LEN_W'(1);
                    valid_reg <= 1'b1;
                    if (period_reg[head] != 32'd0)
                        deadline_reg[head] <= head_dl + 64'(period_reg[head]);
                    else
                        deadline_reg[head] <= '0;
                end
                OP_SCHED:
                begin
                    if (found)
                    begin
                        for (int i = 0; i < NUM_ENTRIES - 1; i++)
                            if (IDX_W'(i) >= found_pos)
                                order_reg[i] <= order_reg[i + 1];
                        len_reg <= len_reg - LEN_W'(1);
                    end
                    deadline_reg[ent_reg] <= abs_reg ? start_reg : now_reg + start_reg;
                    period_reg[ent_reg] <= rper_reg;
                end
                OP_CANCEL:
                begin
                    if (found)
                    begin
                        for (int i = 0; i < NUM_ENTRIES - 1; i++)
                            if (IDX_W'(i) >= found_pos)
                                order_reg[i] <= order_reg[i + 1];
                        len_reg <= len_reg - LEN_W'(1);
                    end
                    deadline_reg[ent_reg] <= '0;
                    period_reg[ent_reg] <= '0;
                end
                OP_INS_STEP:
                begin
                    if (status.ins_done && (len_reg < LEN_W'(NUM_ENTRIES)))
                    begin
                        for (int i = 1; i < NUM_ENTRIES; i++)
                            if (LEN_W'(i) > pos_reg)
                                order_reg[i] <= order_reg[i - 1];
                        order_reg[pos_idx] <= ins_reg;
                        len_reg <= len_reg + LEN_W'(1);
                    end
                end
                OP_EMIT_CMP, OP_EMIT_QUERY, OP_EMIT_TIME:
                begin
                    valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                now_reg <= tb_next + 64'(sample);
                ent_reg <= IDX_W'(entry_index);
                ent_ok_reg <= status.entry_ok;
                abs_reg <= absolute_start;
                start_reg <= start_time;
                rper_reg <= repeat_period;
                fires_reg <= '0;
            end
            OP_FIRE:
            begin
                fires_reg <= fires_reg + FIRE_W'(1);
                ins_reg <= head;
                pos_reg <= '0;
                rkind_reg <= RES_FIRED;
                fired_reg <= 4'(head);
                cmp_reg <= '0;
                has_reg <= 1'b0;
                last_reg <= 1'b0;
            end
            OP_SCHED:
            begin
                ins_reg <= ent_reg;
                pos_reg <= '0;
            end
            OP_INS_STEP:
            begin
                if (!status.ins_done)
                    pos_reg <= pos_reg + LEN_W'(1);
            end
            OP_EMIT_CMP:
            begin
                rkind_reg <= RES_COMPARE;
                fired_reg <= '0;
                cmp_reg <= 16'(next_dl & CNT_MASK);
                has_reg <= 1'b0;
                last_reg <= 1'b1;
            end
            OP_EMIT_QUERY:
            begin
                rkind_reg <= RES_STATUS;
                fired_reg <= '0;
                cmp_reg <= '0;
                has_reg <= !(ent_ok_reg && found);
                last_reg <= 1'b1;
            end
            OP_EMIT_TIME:
            begin
                rkind_reg <= RES_TIME;
                fired_reg <= '0;
                cmp_reg <= '0;
                has_reg <= 1'b0;
                last_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = valid_reg;
    assign result_kind = rkind_reg;
    assign fired_entry = fired_reg;
    assign compare_value = cmp_reg;
    assign has_fired = has_reg;
    assign time_now = now_reg;
    assign last_of_run = last_reg;

endmodule

### src/deadline_timer_queue_unit.sv
// Top level of the deadline timer queue: controller and datapath.
// A read-time or query beat gives its result from a register after start; a schedule
// holds busy while it walks the queue slots to find its insertion point, and goes on
// to emit a compare value when the entry lands at the head, shown as busy falls.
// A compare event fires each due entry in turn, walks the sorted queue to reinsert each
// periodic entry before the next firing, and then emits the compare value. The receiver
// cannot stall. Reset is asynchronous, active low: queue empty, deadlines and periods zero.
module deadline_timer_queue_unit
    import dtq_pkg::*;
#(
    parameter int NUM_ENTRIES = 16,
    parameter int MAX_FIRES = 32,
    parameter int COUNTER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [2:0]  kind,
    input  logic [15:0] counter_sample,
    input  logic [3:0]  entry_index,
    input  logic        absolute_start,
    input  logic [63:0] start_time,
    input  logic [31:0] repeat_period,
    output logic        result_valid,
    output logic [1:0]  result_kind,
    output logic [3:0]  fired_entry,
    output logic [15:0] compare_value,
    output logic        has_fired,
    output logic [63:0] time_now,
    output logic        last_of_run
);

    // The controller steps through each beat; the datapath holds the queue and the
    // entry tables and reports back the few conditions that steer the sequence.
    dp_cmd_t    cmd;
    dp_status_t status;

    dtq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Registered results leave at most one per cycle, each shown for a single cycle.
    dtq_datapath #(
        .NUM_ENTRIES   (NUM_ENTRIES),
        .MAX_FIRES     (MAX_FIRES),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .counter_sample (counter_sample),
        .entry_index    (entry_index),
        .absolute_start (absolute_start),
        .start_time     (start_time),
        .repeat_period  (repeat_period),
        .result_valid   (result_valid),
        .result_kind    (result_kind),
        .fired_entry    (fired_entry),
        .compare_value  (compare_value),
        .has_fired      (has_fired),
        .time_now       (time_now),
        .last_of_run    (last_of_run)
    );

endmodule
